// ===== hdl/sgwf_pkg.sv =====
package sgwf_pkg;

  localparam int SGWF_STRIP_DEPTH       = 64;
  localparam int SGWF_DISPLAY_POSITIONS = 16;

  localparam int PIX_W       = 35;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int IDX_W       = 6;
  localparam int OP_W        = 2;
  localparam int SEG_IDX_W   = 4;
  localparam int INTERVAL_W  = 16;
  localparam int GAP_W       = 8;
  localparam int COUNT_W     = 7;
  localparam int SPAN_W      = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = ((IDX_W + PIX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((SEG_IDX_W + PIX_W + 7) / 8) * 8;
  localparam int PC_W        = 5;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INTERVAL = 2'd0,
    REG_GAP      = 2'd1,
    REG_COUNT    = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    UOP_NONE,
    UOP_ACCEPT,
    UOP_LOAD,
    UOP_START,
    UOP_STOP,
    UOP_TICK,
    UOP_CLR_TICKS,
    UOP_REM_INIT,
    UOP_REM_STEP,
    UOP_REM_DONE,
    UOP_ADVANCE,
    UOP_ZERO_OFS,
    UOP_FETCH,
    UOP_EMIT
  } uop_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_OP_LOAD,
    COND_OP_STOP,
    COND_OP_TICK,
    COND_INACTIVE,
    COND_TICK_SHORT,
    COND_TOTAL_ZERO,
    COND_OFS_LT_TOTAL,
    COND_CNT_NZ,
    COND_EMIT_MORE
  } cond_t;

  typedef struct packed {
    uop_t            uop;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic op_load;
    logic op_stop;
    logic op_tick;
    logic inactive;
    logic tick_short;
    logic total_zero;
    logic ofs_lt_total;
    logic cnt_nz;
    logic emit_more;
  } dp_status_t;

  // Program addresses.
  localparam logic [PC_W-1:0] S_WAIT      = 5'd0;
  localparam logic [PC_W-1:0] S_DISP_LOAD = 5'd1;
  localparam logic [PC_W-1:0] S_DISP_STOP = 5'd2;
  localparam logic [PC_W-1:0] S_DISP_TICK = 5'd3;
  localparam logic [PC_W-1:0] S_START     = 5'd4;
  localparam logic [PC_W-1:0] S_START_CHK = 5'd5;
  localparam logic [PC_W-1:0] S_START_GO  = 5'd6;
  localparam logic [PC_W-1:0] S_LOAD      = 5'd7;
  localparam logic [PC_W-1:0] S_STOP      = 5'd8;
  localparam logic [PC_W-1:0] S_TICK_CHK  = 5'd9;
  localparam logic [PC_W-1:0] S_TICK_INC  = 5'd10;
  localparam logic [PC_W-1:0] S_TICK_CMP  = 5'd11;
  localparam logic [PC_W-1:0] S_STEP      = 5'd12;
  localparam logic [PC_W-1:0] S_REM_INIT  = 5'd13;
  localparam logic [PC_W-1:0] S_REM_LOOP  = 5'd14;
  localparam logic [PC_W-1:0] S_REM_DONE  = 5'd15;
  localparam logic [PC_W-1:0] S_ADVANCE   = 5'd16;
  localparam logic [PC_W-1:0] S_EMPTY     = 5'd17;
  localparam logic [PC_W-1:0] S_FRAME     = 5'd18;
  localparam logic [PC_W-1:0] S_EMIT      = 5'd19;
  localparam logic [PC_W-1:0] S_END       = 5'd20;

  // Control store. A taken condition loads the target, otherwise the step
  // counter moves on by one.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      S_WAIT:      w = '{UOP_ACCEPT,    COND_NO_REQ,       S_WAIT};
      S_DISP_LOAD: w = '{UOP_NONE,      COND_OP_LOAD,      S_LOAD};
      S_DISP_STOP: w = '{UOP_NONE,      COND_OP_STOP,      S_STOP};
      S_DISP_TICK: w = '{UOP_NONE,      COND_OP_TICK,      S_TICK_CHK};
      S_START:     w = '{UOP_START,     COND_NEVER,        S_WAIT};
      S_START_CHK: w = '{UOP_NONE,      COND_INACTIVE,     S_WAIT};
      S_START_GO:  w = '{UOP_NONE,      COND_ALWAYS,       S_FRAME};
      S_LOAD:      w = '{UOP_LOAD,      COND_ALWAYS,       S_WAIT};
      S_STOP:      w = '{UOP_STOP,      COND_ALWAYS,       S_WAIT};
      S_TICK_CHK:  w = '{UOP_NONE,      COND_INACTIVE,     S_WAIT};
      S_TICK_INC:  w = '{UOP_TICK,      COND_NEVER,        S_WAIT};
      S_TICK_CMP:  w = '{UOP_NONE,      COND_TICK_SHORT,   S_WAIT};
      S_STEP:      w = '{UOP_CLR_TICKS, COND_TOTAL_ZERO,   S_EMPTY};
      S_REM_INIT:  w = '{UOP_REM_INIT,  COND_OFS_LT_TOTAL, S_ADVANCE};
      S_REM_LOOP:  w = '{UOP_REM_STEP,  COND_CNT_NZ,       S_REM_LOOP};
      S_REM_DONE:  w = '{UOP_REM_DONE,  COND_NEVER,        S_WAIT};
      S_ADVANCE:   w = '{UOP_ADVANCE,   COND_ALWAYS,       S_FRAME};
      S_EMPTY:     w = '{UOP_ZERO_OFS,  COND_NEVER,        S_WAIT};
      S_FRAME:     w = '{UOP_FETCH,     COND_NEVER,        S_WAIT};
      S_EMIT:      w = '{UOP_EMIT,      COND_EMIT_MORE,    S_EMIT};
      S_END:       w = '{UOP_NONE,      COND_ALWAYS,       S_WAIT};
      default:     w = '{UOP_NONE,      COND_ALWAYS,       S_WAIT};
    endcase
    return w;
  endfunction

  // Row-major glyph to display order: bit p takes row p/5, column 4 - p%5.
  function automatic logic [PIX_W-1:0] pack_glyph(input logic [PIX_W-1:0] g);
    logic [PIX_W-1:0] r;
    r = '0;
    for (int row = 0; row < GLYPH_ROWS; row++) begin
      for (int col = 0; col < GLYPH_COLS; col++) begin
        r[row*GLYPH_COLS + col] = g[row*GLYPH_COLS + (GLYPH_COLS-1-col)];
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/scrolling_glyph_window_framer.sv =====
// A load in range is written to the strip memory, a stop clears the active flag, a tick
// while idle is dropped and a tick below the interval only counts; a start that leaves the
// strip active and a stepping tick fetch from the strip memory and then stream a frame.
// Throughput: a frame streams one result per cycle from the strip memory's read port while
// the sink is ready; when the registers shrank the cycle below the current offset, a stepping
// tick first runs a bit-serial remainder.
// Reset (rst_n low, synchronous) clears the registers, the scroll state and the output.
module scrolling_glyph_window_framer #(
  parameter int STRIP_DEPTH       = sgwf_pkg::SGWF_STRIP_DEPTH,
  parameter int DISPLAY_POSITIONS = sgwf_pkg::SGWF_DISPLAY_POSITIONS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sgwf_pkg::IN_TDATA_W-1:0]   in_tdata,   // glyph_index, glyph_pixels, zero pad
  input  logic [sgwf_pkg::OP_W-1:0]         in_tuser,   // operation
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sgwf_pkg::OUT_TDATA_W-1:0]  out_tdata,  // segment_index, segment_bits, zero pad
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgwf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgwf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sgwf_pkg::*;

  uop_t                 uop;
  dp_status_t           st;
  logic [SEG_IDX_W-1:0] seg_idx;
  logic [PIX_W-1:0]     seg_bits;

  sgwf_useq u_useq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .st        (st),
    .uop       (uop),
    .in_tready (in_tready)
  );

  sgwf_dpath #(
    .STRIP_DEPTH       (STRIP_DEPTH),
    .DISPLAY_POSITIONS (DISPLAY_POSITIONS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .uop       (uop),
    .st        (st),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_idx    (in_tdata[IDX_W-1:0]),
    .in_pix    (in_tdata[IDX_W +: PIX_W]),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_idx   (seg_idx),
    .out_bits  (seg_bits),
    .out_last  (out_tlast)
  );

  assign cfg_ready = 1'b1;
  assign out_tdata = {{(OUT_TDATA_W - SEG_IDX_W - PIX_W){1'b0}}, seg_bits, seg_idx};

endmodule

// ===== hdl/sgwf_useq.sv =====
module sgwf_useq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  sgwf_pkg::dp_status_t st,
  output sgwf_pkg::uop_t     uop,
  output logic               in_tready
);
  import sgwf_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  uword_t          word;
  logic            take;

  assign word = ucode(pc_r);

  always_comb begin
    case (word.cond)
      COND_NEVER:        take = 1'b0;
      COND_ALWAYS:       take = 1'b1;
      COND_NO_REQ:       take = !in_tvalid;
      COND_OP_LOAD:      take = st.op_load;
      COND_OP_STOP:      take = st.op_stop;
      COND_OP_TICK:      take = st.op_tick;
      COND_INACTIVE:     take = st.inactive;
      COND_TICK_SHORT:   take = st.tick_short;
      COND_TOTAL_ZERO:   take = st.total_zero;
      COND_OFS_LT_TOTAL: take = st.ofs_lt_total;
      COND_CNT_NZ:       take = st.cnt_nz;
      COND_EMIT_MORE:    take = st.emit_more;
      default:           take = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = take ? word.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign uop       = word.uop;
  assign in_tready = (word.uop == UOP_ACCEPT);

endmodule

// ===== hdl/sgwf_dpath.sv =====
module sgwf_dpath #(
  parameter int STRIP_DEPTH       = sgwf_pkg::SGWF_STRIP_DEPTH,
  parameter int DISPLAY_POSITIONS = sgwf_pkg::SGWF_DISPLAY_POSITIONS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sgwf_pkg::uop_t                  uop,
  output sgwf_pkg::dp_status_t            st,
  input  logic                            in_tvalid,
  input  logic [sgwf_pkg::OP_W-1:0]       in_op,
  input  logic [sgwf_pkg::IDX_W-1:0]      in_idx,
  input  logic [sgwf_pkg::PIX_W-1:0]      in_pix,
  input  logic                            cfg_valid,
  input  logic [sgwf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgwf_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sgwf_pkg::SEG_IDX_W-1:0]  out_idx,
  output logic [sgwf_pkg::PIX_W-1:0]      out_bits,
  output logic                            out_last
);
  import sgwf_pkg::*;

  localparam int AW = (STRIP_DEPTH > 1) ? $clog2(STRIP_DEPTH) : 1;
  localparam int KW = (DISPLAY_POSITIONS > 1) ? $clog2(DISPLAY_POSITIONS) : 1;
  localparam logic [SPAN_W-1:0] DEPTH_SPAN = SPAN_W'(STRIP_DEPTH);
  localparam logic [KW-1:0]     K_LAST     = KW'(DISPLAY_POSITIONS - 1);
  localparam logic [3:0]        REM_BITS   = 4'(SPAN_W - 1);

  // Configuration.
  logic [INTERVAL_W-1:0] interval_r, interval_nxt;
  logic [GAP_W-1:0]      gap_r, gap_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;

  // Scroll state.
  logic [SPAN_W-1:0]     ofs_r, ofs_nxt;
  logic [INTERVAL_W-1:0] ticks_r, ticks_nxt;
  logic                  active_r, active_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Working registers.
  op_t                   op_r, op_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [PIX_W-1:0]      pix_r, pix_nxt;
  logic [SPAN_W-1:0]     rem_r, rem_nxt;
  logic [SPAN_W-1:0]     dvd_r, dvd_nxt;
  logic [3:0]            cnt_r, cnt_nxt;
  logic [SPAN_W-1:0]     ptr_r, ptr_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic                  blank_r, blank_nxt;
  logic [SEG_IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [PIX_W-1:0]      out_bits_r, out_bits_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [PIX_W-1:0]      strip_mem [STRIP_DEPTH];
  logic [PIX_W-1:0]      rd_data_r;

  logic [SPAN_W-1:0]     count_eff, total;
  logic [SPAN_W:0]       ofs_inc, ptr_inc, rem_sh, rem_diff;
  logic [SPAN_W-1:0]     ofs_wrap, ptr_src, ptr_wrap;
  logic                  src_blank, emit_free, rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [AW+IDX_W-1:0]   idx_ext;
  logic [KW+SEG_IDX_W-1:0] k_ext;

  assign count_eff = ({2'b00, count_r} > DEPTH_SPAN) ? DEPTH_SPAN : {2'b00, count_r};
  assign total     = count_eff + {1'b0, gap_r};

  assign ofs_inc  = {1'b0, ofs_r} + 1'b1;
  assign ofs_wrap = (ofs_inc == {1'b0, total}) ? '0 : ofs_inc[SPAN_W-1:0];

  // The first fetch of a frame starts at the offset, later ones follow the pointer.
  assign ptr_src   = (uop == UOP_FETCH) ? ofs_r : ptr_r;
  assign ptr_inc   = {1'b0, ptr_src} + 1'b1;
  assign ptr_wrap  = (ptr_inc == {1'b0, total}) ? '0 : ptr_inc[SPAN_W-1:0];
  assign src_blank = (total == '0) || (ptr_src >= count_eff);

  assign emit_free = !out_valid_r || out_ready;
  assign rd_en     = (uop == UOP_FETCH) || ((uop == UOP_EMIT) && emit_free);
  assign rd_addr   = ptr_src[AW-1:0];
  assign idx_ext   = {{AW{1'b0}}, idx_r};
  assign wr_addr   = idx_ext[AW-1:0];
  assign wr_en     = (uop == UOP_LOAD) && ({3'b000, idx_r} < DEPTH_SPAN);

  // One restoring remainder step per cycle, dividend taken MSB first.
  assign rem_sh   = {rem_r, dvd_r[SPAN_W-1]};
  assign rem_diff = rem_sh - {1'b0, total};

  assign k_ext = {{SEG_IDX_W{1'b0}}, k_r};

  always_comb begin
    interval_nxt  = interval_r;
    gap_nxt       = gap_r;
    count_nxt     = count_r;
    ofs_nxt       = ofs_r;
    ticks_nxt     = ticks_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    pix_nxt       = pix_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    k_nxt         = k_r;
    blank_nxt     = blank_r;
    out_idx_nxt   = out_idx_r;
    out_bits_nxt  = out_bits_r;
    out_last_nxt  = out_last_r;

    if (cfg_valid) begin
      case (cfg_index)
        REG_INTERVAL: interval_nxt = cfg_data;
        REG_GAP:      gap_nxt      = cfg_data[GAP_W-1:0];
        REG_COUNT:    count_nxt    = cfg_data[COUNT_W-1:0];
        default:      ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (uop)
      UOP_ACCEPT: begin
        if (in_tvalid) begin
          op_nxt  = op_t'(in_op);
          idx_nxt = in_idx;
          pix_nxt = in_pix;
        end
      end
      UOP_START: begin
        ofs_nxt    = '0;
        ticks_nxt  = '0;
        active_nxt = (count_eff != '0);
      end
      UOP_STOP: active_nxt = 1'b0;
      UOP_TICK: begin
        if (ticks_r != '1) begin
          ticks_nxt = ticks_r + 1'b1;
        end
      end
      UOP_CLR_TICKS: ticks_nxt = '0;
      UOP_REM_INIT: begin
        rem_nxt = '0;
        dvd_nxt = ofs_r;
        cnt_nxt = REM_BITS;
      end
      UOP_REM_STEP: begin
        rem_nxt = (rem_sh >= {1'b0, total}) ? rem_diff[SPAN_W-1:0] : rem_sh[SPAN_W-1:0];
        dvd_nxt = {dvd_r[SPAN_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end
      UOP_REM_DONE: ofs_nxt = rem_r;
      UOP_ADVANCE:  ofs_nxt = ofs_wrap;
      UOP_ZERO_OFS: ofs_nxt = '0;
      UOP_FETCH: begin
        k_nxt     = '0;
        ptr_nxt   = ptr_wrap;
        blank_nxt = src_blank;
      end
      UOP_EMIT: begin
        if (emit_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = k_ext[SEG_IDX_W-1:0];
          out_bits_nxt  = blank_r ? '0 : pack_glyph(rd_data_r);
          out_last_nxt  = (k_r == K_LAST);
          k_nxt         = k_r + 1'b1;
          ptr_nxt       = ptr_wrap;
          blank_nxt     = src_blank;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= '0;
      gap_r       <= '0;
      count_r     <= '0;
      ofs_r       <= '0;
      ticks_r     <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      interval_r  <= interval_nxt;
      gap_r       <= gap_nxt;
      count_r     <= count_nxt;
      ofs_r       <= ofs_nxt;
      ticks_r     <= ticks_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    pix_r      <= pix_nxt;
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    cnt_r      <= cnt_nxt;
    ptr_r      <= ptr_nxt;
    k_r        <= k_nxt;
    blank_r    <= blank_nxt;
    out_idx_r  <= out_idx_nxt;
    out_bits_r <= out_bits_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      strip_mem[wr_addr] <= pix_r;
    end
    if (rd_en) begin
      rd_data_r <= strip_mem[rd_addr];
    end
  end

  always_comb begin
    st.op_load      = (op_r == OP_LOAD);
    st.op_stop      = (op_r == OP_STOP);
    st.op_tick      = (op_r == OP_TICK);
    st.inactive     = !active_r;
    st.tick_short   = (ticks_r < interval_r);
    st.total_zero   = (total == '0);
    st.ofs_lt_total = (ofs_r < total);
    st.cnt_nz       = (cnt_r != '0);
    st.emit_more    = !(emit_free && (k_r == K_LAST));
  end

  assign out_valid = out_valid_r;
  assign out_idx   = out_idx_r;
  assign out_bits  = out_bits_r;
  assign out_last  = out_last_r;

endmodule

// ===== hdl/sgwf_checker.sv =====
module sgwf_checker #(
  parameter int DISPLAY_POSITIONS = sgwf_pkg::SGWF_DISPLAY_POSITIONS
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [sgwf_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);
  import sgwf_pkg::*;

  localparam logic [6:0] EXP_LAST = 7'(DISPLAY_POSITIONS - 1);

  // Position the next result on the output side should carry.
  logic [6:0] exp_r, exp_nxt;

  always_comb begin
    exp_nxt = exp_r;
    if (out_tvalid && out_tready) begin
      exp_nxt = out_tlast ? '0 : exp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= '0;
    end else begin
      exp_r <= exp_nxt;
    end
  end

  // Frames are whole and in display order.
  a_seg_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[SEG_IDX_W-1:0] == exp_r[SEG_IDX_W-1:0])
    else $error("segment index out of order");

  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == (exp_r == EXP_LAST))
    else $error("frame end misplaced");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // One request is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind scrolling_glyph_window_framer sgwf_checker #(
  .DISPLAY_POSITIONS (DISPLAY_POSITIONS)
) u_sgwf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
